// File: hw/rtl/assert_macros.svh
// Assertion helper macros for the cache tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SLCT_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checked on every clock edge, reset included.
`define SLCT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) (cond)) else $error(msg);

`endif

// File: hw/rtl/slct_pkg.sv
// Shared types and constants of the cache tracker.
`default_nettype none
package slct_pkg;

   localparam int ADDR_W      = 64;
   localparam int TAG_W       = 64;
   localparam int SET_INDEX_W = 6;
   localparam int OUT_COUNT_W = 32;

   localparam int SET_BITS_W   = 3;
   localparam int WAYS_FIELD_W = 3;
   localparam int BLOCK_BITS_W = 6;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_WAYS       = 2'd1,
      CSR_BLOCK_BITS = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_MODIFY = 2'd2,
      ACT_FETCH  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_LOOKUP = 1'b1
   } state_type;

   // Per-cycle controls from the sequencer.
   typedef struct packed {
      logic req_ready;
      logic mem_rd_en;
      logic mem_wr_en;
      logic commit;
   } ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/slct_row_mem.sv
// One-port-write, one-port-read set row memory with registered read data.
`default_nettype none
module slct_row_mem #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 264
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/slct_way_logic.sv
// Tag compare, victim choice and LRU rank update for one set row.
`default_nettype none
module slct_way_logic import slct_pkg::*; #(
   parameter int MAX_WAYS = 4,
   parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
   input  wire logic [TAG_W-1:0]                   tag_i,
   input  wire logic [WCNT_W-1:0]                  ways_i,
   input  wire logic [MAX_WAYS-1:0]                valid_i,
   input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]     tags_i,
   input  wire logic [MAX_WAYS-1:0][WAY_W-1:0]     ranks_i,
   output outcome_type                             outcome_o,
   output logic      [MAX_WAYS-1:0]                valid_o,
   output logic      [MAX_WAYS-1:0][TAG_W-1:0]     tags_o,
   output logic      [MAX_WAYS-1:0][WAY_W-1:0]     ranks_o
);

   logic [MAX_WAYS-1:0] used;
   logic                hit;
   logic                free;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    evict_way;
   logic [WAY_W-1:0]    chosen;
   logic [WAY_W:0]      old_rank;

   // Priority search: lowest matching way, lowest free way, oldest way.
   always_comb begin
      hit       = 1'b0;
      free      = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      evict_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         used[w] = (w < int'(ways_i));
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!hit && used[w] && valid_i[w] && (tags_i[w] == tag_i)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!free && used[w] && !valid_i[w]) begin
            free     = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (used[w] && (ranks_i[w] > ranks_i[evict_way])) begin
            evict_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      if (hit) begin
         outcome_o = OUT_HIT;
         chosen    = hit_way;
      end else if (free) begin
         outcome_o = OUT_FILL;
         chosen    = free_way;
      end else begin
         outcome_o = OUT_EVICT;
         chosen    = evict_way;
      end
   end

   // A fill ages every other valid line; otherwise only the younger ones.
   always_comb begin
      if (outcome_o == OUT_FILL) begin
         old_rank = (WAY_W + 1)'(MAX_WAYS);
      end else begin
         old_rank = {1'b0, ranks_i[chosen]};
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAY_W'(w) == chosen) begin
            ranks_o[w] = '0;
            tags_o[w]  = tag_i;
            valid_o[w] = 1'b1;
         end else begin
            tags_o[w]  = tags_i[w];
            valid_o[w] = valid_i[w];
            if (used[w] && valid_i[w] && ({1'b0, ranks_i[w]} < old_rank) &&
                (int'(ranks_i[w]) < MAX_WAYS - 1)) begin
               ranks_o[w] = ranks_i[w] + WAY_W'(1);
            end else begin
               ranks_o[w] = ranks_i[w];
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/set_associative_lru_cache_tracker_unit.sv
// Top level of the set-associative LRU cache tracker.
// Tracks tags, valid bits and exact LRU ranks of a set-associative cache and
// classifies each data access (load, store, modify) as hit, miss into a free
// line, or miss with eviction, with saturating hit/miss/eviction totals.
// Instruction fetches are accepted in IDLE and produce no result item.
// For each data item, the accept edge launches the read of its set row from
// the row memory; LOOKUP then writes the updated row back and loads the
// result register once that register is free. A new item is taken only
// after the last one has written its row back; a result still waiting at
// the output holds up the write-back of the next item. Set, tag and block
// offset follow set_bits and block_bits; the ways register limits the ways
// searched. Valid bits are flip-flops cleared by reset, so the block is ready
// directly after reset with no clearing pass. The user must write registers
// over the APB-style port only while idle; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module set_associative_lru_cache_tracker_unit import slct_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 4,
   parameter int COUNT_WIDTH  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_action,
   input  wire logic [ADDR_W-1:0]      req_address,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [1:0]             rsp_outcome,
   output logic                        rsp_extra_hit,
   output logic      [SET_INDEX_W-1:0] rsp_set_index,
   output logic      [OUT_COUNT_W-1:0] rsp_hits_total,
   output logic      [OUT_COUNT_W-1:0] rsp_misses_total,
   output logic      [OUT_COUNT_W-1:0] rsp_evictions_total,
   // configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [CSR_DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS = 2 ** SET_W;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
   localparam int ROW_W    = MAX_WAYS * (TAG_W + WAY_W);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [SET_BITS_W-1:0]   set_bits_ff,   set_bits_in;
   logic [WAYS_FIELD_W-1:0] ways_ff,       ways_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic                    csr_wr;
   csr_index_type           csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      set_bits_in   = set_bits_ff;
      ways_in       = ways_ff;
      block_bits_in = block_bits_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_SET_BITS:   set_bits_in   = csr_pwdata[SET_BITS_W-1:0];
            CSR_WAYS:       ways_in       = csr_pwdata[WAYS_FIELD_W-1:0];
            CSR_BLOCK_BITS: block_bits_in = csr_pwdata[BLOCK_BITS_W-1:0];
            default:        ; // unknown register: write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_SET_BITS:   csr_prdata = CSR_DATA_W'(set_bits_ff);
         CSR_WAYS:       csr_prdata = CSR_DATA_W'(ways_ff);
         CSR_BLOCK_BITS: csr_prdata = CSR_DATA_W'(block_bits_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         ways_ff       <= WAYS_FIELD_W'(1);
         block_bits_ff <= '0;
      end else begin
         set_bits_ff   <= set_bits_in;
         ways_ff       <= ways_in;
         block_bits_ff <= block_bits_in;
      end
   end

   // Effective set bit count and way count after clamping.
   logic [SET_BITS_W-1:0] sb_eff;
   logic [WCNT_W-1:0]     ways_eff;

   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = SET_BITS_W'(MAX_SET_BITS);
      end else begin
         sb_eff = set_bits_ff;
      end
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Address split on the incoming item
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]         addr_shifted;
   logic [SET_W-1:0]          set_mask;
   logic [SET_W-1:0]          set_calc;
   logic [BLOCK_BITS_W:0]     tag_shift;
   logic [TAG_W-1:0]          tag_calc;

   always_comb begin
      addr_shifted = req_address >> block_bits_ff;
      set_mask     = (SET_W'(1) << sb_eff) - SET_W'(1);
      set_calc     = addr_shifted[SET_W-1:0] & set_mask;
      tag_shift    = {1'b0, block_bits_ff} + (BLOCK_BITS_W + 1)'(sb_eff);
      // shift of 64 or more leaves no tag bits
      if (tag_shift[BLOCK_BITS_W]) begin
         tag_calc = '0;
      end else begin
         tag_calc = req_address >> tag_shift[BLOCK_BITS_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: IDLE accepts, LOOKUP modifies and writes back the row
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   ctrl_type  ctrl;
   logic      is_data;
   logic      rsp_valid_ff, rsp_valid_in;

   assign is_data = (action_type'(req_action) != ACT_FETCH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid && is_data) state_in = ST_LOOKUP;
         ST_LOOKUP: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.mem_rd_en = req_valid && is_data;
         end
         ST_LOOKUP: begin
            // commit only when the result register is free this edge
            ctrl.commit    = !rsp_valid_ff || rsp_ready;
            ctrl.mem_wr_en = ctrl.commit;
         end
         default: ctrl = '0;
      endcase
   end

   assign req_ready = ctrl.req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Item fields held for the lookup state.
   action_type       action_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mem_rd_en) begin
         action_ff <= action_type'(req_action);
         set_ff    <= set_calc;
         tag_ff    <= tag_calc;
      end
   end

   // ---------------------------------------------------------------------
   // Set row memory (tags and ranks) and valid flip-flops
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]                     rd_row;
   logic [ROW_W-1:0]                     wr_row;
   logic [MAX_WAYS-1:0][TAG_W-1:0]       rd_tags,  wr_tags;
   logic [MAX_WAYS-1:0][WAY_W-1:0]       rd_ranks, wr_ranks;
   logic [MAX_WAYS-1:0]                  row_valid, new_valid;
   logic [MAX_WAYS-1:0]                  valid_ff [NUM_SETS];
   outcome_type                          outcome;

   slct_row_mem #(
      .ADDR_W (SET_W),
      .DATA_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (ctrl.mem_rd_en),
      .rd_addr (set_calc),
      .rd_data (rd_row),
      .wr_en   (ctrl.mem_wr_en),
      .wr_addr (set_ff),
      .wr_data (wr_row)
   );

   assign {rd_ranks, rd_tags} = rd_row;
   assign wr_row              = {wr_ranks, wr_tags};
   assign row_valid           = valid_ff[set_ff];

   // Read and write of the same row never overlap: the sequencer only
   // reads in IDLE and only writes in LOOKUP, so no forwarding is needed.
   slct_way_logic #(
      .MAX_WAYS (MAX_WAYS),
      .WAY_W    (WAY_W),
      .WCNT_W   (WCNT_W)
   ) u_way_logic (
      .tag_i     (tag_ff),
      .ways_i    (ways_eff),
      .valid_i   (row_valid),
      .tags_i    (rd_tags),
      .ranks_i   (rd_ranks),
      .outcome_o (outcome),
      .valid_o   (new_valid),
      .tags_o    (wr_tags),
      .ranks_o   (wr_ranks)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (ctrl.mem_wr_en) begin
         valid_ff[set_ff] <= new_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Saturating totals
   // ---------------------------------------------------------------------
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(
      input logic [COUNT_WIDTH-1:0] c,
      input logic                   en
   );
      if (en && (c != '1)) begin
         return c + COUNT_WIDTH'(1);
      end
      return c;
   endfunction

   logic [COUNT_WIDTH-1:0] hits_ff,  hits_in;
   logic [COUNT_WIDTH-1:0] miss_ff,  miss_in;
   logic [COUNT_WIDTH-1:0] evict_ff, evict_in;
   logic [COUNT_WIDTH-1:0] hits_step;

   // a modify's store part always hits: second increment
   always_comb begin
      hits_step = sat_inc(hits_ff, outcome == OUT_HIT);
      hits_in   = hits_ff;
      miss_in   = miss_ff;
      evict_in  = evict_ff;
      if (ctrl.commit) begin
         hits_in  = sat_inc(hits_step, action_ff == ACT_MODIFY);
         miss_in  = sat_inc(miss_ff, outcome != OUT_HIT);
         evict_in = sat_inc(evict_ff, outcome == OUT_EVICT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff  <= '0;
         miss_ff  <= '0;
         evict_ff <= '0;
      end else begin
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         evict_ff <= evict_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. Totals only move on commit, which needs this
   // register free, so they are shown straight from the counters.
   // ---------------------------------------------------------------------
   outcome_type      outcome_ff;
   logic             extra_hit_ff;
   logic [SET_W-1:0] rsp_set_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         outcome_ff   <= outcome;
         extra_hit_ff <= (action_ff == ACT_MODIFY);
         rsp_set_ff   <= set_ff;
      end
   end

   logic [SET_INDEX_W+SET_W-1:0]       set_ext;
   logic [OUT_COUNT_W+COUNT_WIDTH-1:0] hits_ext, miss_ext, evict_ext;

   assign set_ext   = {{SET_INDEX_W{1'b0}}, rsp_set_ff};
   assign hits_ext  = {{OUT_COUNT_W{1'b0}}, hits_ff};
   assign miss_ext  = {{OUT_COUNT_W{1'b0}}, miss_ff};
   assign evict_ext = {{OUT_COUNT_W{1'b0}}, evict_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_extra_hit       = extra_hit_ff;
   assign rsp_set_index       = set_ext[SET_INDEX_W-1:0];
   assign rsp_hits_total      = hits_ext[OUT_COUNT_W-1:0];
   assign rsp_misses_total    = miss_ext[OUT_COUNT_W-1:0];
   assign rsp_evictions_total = evict_ext[OUT_COUNT_W-1:0];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `SLCT_ASSERT(a_rsp_from_lookup, $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP), "result without lookup")
   `SLCT_ASSERT_ALWAYS(a_no_rd_wr_overlap, !(ctrl.mem_rd_en && ctrl.mem_wr_en), "row read and write overlap")
   `SLCT_ASSERT(a_evict_le_miss, evict_ff <= miss_ff, "more evictions than misses")
   `SLCT_ASSERT(a_hits_monotonic, !$past(reset) |-> (hits_ff >= $past(hits_ff)), "hit total went down")

endmodule
`default_nettype wire
